@@ sv/obb2d_sat_pkg.sv @@
// ============================================================================
// obb2d_sat_pkg
// Shared constants, edge pairing tables and pipeline control types for the
// 2D oriented box separating axis test.
// ============================================================================
package obb2d_sat_pkg;

    // Edge order: left u, left v, right u, right v
    localparam int NUM_EDGES = 4;
    // Distinct edge-by-edge dot products (dot is symmetric)
    localparam int NUM_PAIRS = 10;

    typedef logic [1:0] edge_idx_t;
    typedef logic [3:0] pair_idx_t;

    // Operands of each distinct edge dot product
    localparam edge_idx_t PAIR_A [NUM_PAIRS] =
        '{2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3};
    localparam edge_idx_t PAIR_B [NUM_PAIRS] =
        '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

    // Dot product slot for axis i against edge j
    localparam pair_idx_t PAIR_OF [NUM_EDGES][NUM_EDGES] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3},
        '{4'd1, 4'd4, 4'd5, 4'd6},
        '{4'd2, 4'd5, 4'd7, 4'd8},
        '{4'd3, 4'd6, 4'd8, 4'd9}
    };

    typedef struct packed {
        logic en_prod;
        logic en_dot;
    } dot_ctl_t;

    typedef struct packed {
        logic en_sum;
        logic en_out;
    } cmp_ctl_t;

endpackage

@@ sv/obb2d_sat_dot.sv @@
// ============================================================================
// obb2d_sat_dot
// Product and dot-product stages: multiply edge and center components,
// then add pairs and take magnitudes.
// ============================================================================
module obb2d_sat_dot #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                   clk,
    input  obb2d_sat_pkg::dot_ctl_t                ctl,
    input  logic signed [COORD_WIDTH-1:0]          edge_x [obb2d_sat_pkg::NUM_EDGES],
    input  logic signed [COORD_WIDTH-1:0]          edge_y [obb2d_sat_pkg::NUM_EDGES],
    input  logic signed [COORD_WIDTH:0]            diff_x,
    input  logic signed [COORD_WIDTH:0]            diff_y,
    output logic        [2*COORD_WIDTH-1:0]        abs_ee [obb2d_sat_pkg::NUM_PAIRS],
    output logic        [2*COORD_WIDTH-1:0]        abs_ec [obb2d_sat_pkg::NUM_EDGES]
);
    import obb2d_sat_pkg::*;

    localparam int PW  = 2*COORD_WIDTH;     // edge x edge product
    localparam int CPW = 2*COORD_WIDTH + 1; // edge x center difference product
    localparam int EW  = PW + 1;            // edge dot sum
    localparam int CW  = CPW + 1;           // center dot sum

    logic signed [PW-1:0]  pp_ee_x_reg [NUM_PAIRS];
    logic signed [PW-1:0]  pp_ee_y_reg [NUM_PAIRS];
    logic signed [CPW-1:0] pp_ec_x_reg [NUM_EDGES];
    logic signed [CPW-1:0] pp_ec_y_reg [NUM_EDGES];
    logic signed [PW-1:0]  pp_ee_x_next [NUM_PAIRS];
    logic signed [PW-1:0]  pp_ee_y_next [NUM_PAIRS];
    logic signed [CPW-1:0] pp_ec_x_next [NUM_EDGES];
    logic signed [CPW-1:0] pp_ec_y_next [NUM_EDGES];

    logic [PW-1:0] abs_ee_reg  [NUM_PAIRS];
    logic [PW-1:0] abs_ec_reg  [NUM_EDGES];
    logic [PW-1:0] abs_ee_next [NUM_PAIRS];
    logic [PW-1:0] abs_ec_next [NUM_EDGES];

    // Products
    always_comb
    begin
        for (int k = 0; k < NUM_PAIRS; k++)
        begin
            pp_ee_x_next[k] = PW'(edge_x[PAIR_A[k]]) * PW'(edge_x[PAIR_B[k]]);
            pp_ee_y_next[k] = PW'(edge_y[PAIR_A[k]]) * PW'(edge_y[PAIR_B[k]]);
        end
        for (int i = 0; i < NUM_EDGES; i++)
        begin
            pp_ec_x_next[i] = CPW'(edge_x[i]) * CPW'(diff_x);
            pp_ec_y_next[i] = CPW'(edge_y[i]) * CPW'(diff_y);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en_prod)
        begin
            pp_ee_x_reg <= pp_ee_x_next;
            pp_ee_y_reg <= pp_ee_y_next;
            pp_ec_x_reg <= pp_ec_x_next;
            pp_ec_y_reg <= pp_ec_y_next;
        end
    end

    // Dot sums and magnitudes; magnitudes fit in PW bits unsigned
    always_comb
    begin
        logic signed [EW-1:0] dot_e;
        logic signed [CW-1:0] dot_c;
        logic signed [EW-1:0] neg_e;
        logic signed [CW-1:0] neg_c;
        for (int k = 0; k < NUM_PAIRS; k++)
        begin
            dot_e = EW'(pp_ee_x_reg[k]) + EW'(pp_ee_y_reg[k]);
            neg_e = -dot_e;
            abs_ee_next[k] = dot_e[EW-1] ? neg_e[PW-1:0] : dot_e[PW-1:0];
        end
        for (int i = 0; i < NUM_EDGES; i++)
        begin
            dot_c = CW'(pp_ec_x_reg[i]) + CW'(pp_ec_y_reg[i]);
            neg_c = -dot_c;
            abs_ec_next[i] = dot_c[CW-1] ? neg_c[PW-1:0] : dot_c[PW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en_dot)
        begin
            abs_ee_reg <= abs_ee_next;
            abs_ec_reg <= abs_ec_next;
        end
    end

    assign abs_ee = abs_ee_reg;
    assign abs_ec = abs_ec_reg;

endmodule

@@ sv/obb2d_sat_cmp.sv @@
// ============================================================================
// obb2d_sat_cmp
// Per-axis sum of edge projections against the doubled center projection,
// then the final overlap decision.
// ============================================================================
module obb2d_sat_cmp #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                            clk,
    input  obb2d_sat_pkg::cmp_ctl_t         ctl,
    input  logic [2*COORD_WIDTH-1:0]        abs_ee [obb2d_sat_pkg::NUM_PAIRS],
    input  logic [2*COORD_WIDTH-1:0]        abs_ec [obb2d_sat_pkg::NUM_EDGES],
    output logic                            overlap
);
    import obb2d_sat_pkg::*;

    localparam int PW = 2*COORD_WIDTH;
    localparam int AW = PW + 2; // sum of four magnitudes
    localparam int DW = PW + 1; // doubled center magnitude

    logic [AW-1:0] acc_reg  [NUM_EDGES];
    logic [DW-1:0] cen_reg  [NUM_EDGES];
    logic [AW-1:0] acc_next [NUM_EDGES];
    logic [DW-1:0] cen_next [NUM_EDGES];
    logic          overlap_reg;
    logic          overlap_next;

    always_comb
    begin
        for (int i = 0; i < NUM_EDGES; i++)
        begin
            acc_next[i] = '0;
            for (int j = 0; j < NUM_EDGES; j++)
            begin
                acc_next[i] = acc_next[i] + AW'(abs_ee[PAIR_OF[i][j]]);
            end
            cen_next[i] = {abs_ec[i], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en_sum)
        begin
            acc_reg <= acc_next;
            cen_reg <= cen_next;
        end
    end

    // Separated on an axis when the edge sum falls strictly below
    always_comb
    begin
        overlap_next = 1'b1;
        for (int i = 0; i < NUM_EDGES; i++)
        begin
            if (acc_reg[i] < AW'(cen_reg[i]))
            begin
                overlap_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en_out)
        begin
            overlap_reg <= overlap_next;
        end
    end

    assign overlap = overlap_reg;

endmodule

@@ sv/obb2d_separating_axis_test.sv @@
// ============================================================================
// obb2d_separating_axis_test
// Separating axis overlap test for two oriented rectangles in the plane.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall) carries one word per box pair: the
//   centers and both full edge vectors of the left and right box, signed
//   fixed point of COORD_WIDTH bits. A word is taken on a rising edge with
//   in_valid high and in_stall low.
//   Output channel (out_valid / out_stall) returns one word per input word,
//   in order: overlap is high when no edge axis (left u, left v, right u,
//   right v) separates the boxes. Touching boxes count as overlapping.
//   Five register stages: input/difference, products, dot magnitudes,
//   per-axis sums, compare. out_valid rises once the word is held in the
//   compare stage. Every stage is a register with its own valid bit, so
//   the pipe takes a new word each cycle while the output is taken.
//   When the receiver stalls, words advance into empty stages and the
//   pipe holds the rest; in_stall rises only once stage one is full and
//   cannot advance, so nothing is dropped or repeated.
//   Reset clears all valid bits; the pipe comes out of reset empty and
//   ready, with no warm-up.
// ============================================================================
module obb2d_separating_axis_test #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] left_center_x,
    input  logic signed [COORD_WIDTH-1:0] left_center_y,
    input  logic signed [COORD_WIDTH-1:0] left_edge_u_x,
    input  logic signed [COORD_WIDTH-1:0] left_edge_u_y,
    input  logic signed [COORD_WIDTH-1:0] left_edge_v_x,
    input  logic signed [COORD_WIDTH-1:0] left_edge_v_y,
    input  logic signed [COORD_WIDTH-1:0] right_center_x,
    input  logic signed [COORD_WIDTH-1:0] right_center_y,
    input  logic signed [COORD_WIDTH-1:0] right_edge_u_x,
    input  logic signed [COORD_WIDTH-1:0] right_edge_u_y,
    input  logic signed [COORD_WIDTH-1:0] right_edge_v_x,
    input  logic signed [COORD_WIDTH-1:0] right_edge_v_y,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          overlap
);
    import obb2d_sat_pkg::*;

    localparam int DIFW = COORD_WIDTH + 1;
    localparam int PW   = 2*COORD_WIDTH;

    // Stage valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;

    // Stage enables: a stage loads when empty or when its successor loads
    logic en1, en2, en3, en4, en_out;

    // Stage one payload: edges in order left u, left v, right u, right v
    logic signed [COORD_WIDTH-1:0] edge_x_reg  [NUM_EDGES];
    logic signed [COORD_WIDTH-1:0] edge_y_reg  [NUM_EDGES];
    logic signed [COORD_WIDTH-1:0] edge_x_next [NUM_EDGES];
    logic signed [COORD_WIDTH-1:0] edge_y_next [NUM_EDGES];
    logic signed [DIFW-1:0]        diff_x_reg, diff_y_reg;
    logic signed [DIFW-1:0]        diff_x_next, diff_y_next;

    logic [PW-1:0] abs_ee [NUM_PAIRS];
    logic [PW-1:0] abs_ec [NUM_EDGES];

    dot_ctl_t dot_ctl;
    cmp_ctl_t cmp_ctl;

    assign en_out = !out_valid_reg || !out_stall;
    assign en4    = !v4_reg || en_out;
    assign en3    = !v3_reg || en4;
    assign en2    = !v2_reg || en3;
    assign en1    = !v1_reg || en2;

    assign in_stall  = !en1;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
            if (en_out)
            begin
                out_valid_reg <= v4_reg;
            end
        end
    end

    // Capture edges; form the center offset one bit wider so it is exact
    always_comb
    begin
        edge_x_next[0] = left_edge_u_x;
        edge_y_next[0] = left_edge_u_y;
        edge_x_next[1] = left_edge_v_x;
        edge_y_next[1] = left_edge_v_y;
        edge_x_next[2] = right_edge_u_x;
        edge_y_next[2] = right_edge_u_y;
        edge_x_next[3] = right_edge_v_x;
        edge_y_next[3] = right_edge_v_y;
        diff_x_next    = DIFW'(right_center_x) - DIFW'(left_center_x);
        diff_y_next    = DIFW'(right_center_y) - DIFW'(left_center_y);
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            edge_x_reg <= edge_x_next;
            edge_y_reg <= edge_y_next;
            diff_x_reg <= diff_x_next;
            diff_y_reg <= diff_y_next;
        end
    end

    assign dot_ctl.en_prod = en2;
    assign dot_ctl.en_dot  = en3;
    assign cmp_ctl.en_sum  = en4;
    assign cmp_ctl.en_out  = en_out;

    obb2d_sat_dot #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dot (
        .clk    (clk),
        .ctl    (dot_ctl),
        .edge_x (edge_x_reg),
        .edge_y (edge_y_reg),
        .diff_x (diff_x_reg),
        .diff_y (diff_y_reg),
        .abs_ee (abs_ee),
        .abs_ec (abs_ec)
    );

    obb2d_sat_cmp #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_cmp (
        .clk     (clk),
        .ctl     (cmp_ctl),
        .abs_ee  (abs_ee),
        .abs_ec  (abs_ec),
        .overlap (overlap)
    );

`ifndef SYNTHESIS
    // Input backs up only when stage one holds a word
    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> v1_reg)
        else $error("in_stall raised with stage one empty");

    // A free output frees the whole pipe
    a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled although output is not stalled");

    // Result ready to take from the compare stage when the receiver never stalls
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !out_stall) ##1 !out_stall ##1 !out_stall
        ##1 !out_stall ##1 !out_stall |=> out_valid)
        else $error("result missing five cycles after acceptance");
`endif

endmodule
